// ===== rtl/core/assert_macros.svh =====
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, held off while arst_n is low
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// concurrent check on clk that also runs during reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/expg_pkg.sv =====
// constants and types of the exp-golomb stream decoder
package expg_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam logic [7:0] PREVENTION_BYTE = 8'h03;
	localparam int DEF_MAX_PREFIX = 31;
	localparam int CODE_W = 32;
	localparam int SIGNED_W = 33;
	localparam int BITS_W = 6;

	// one decoded code before the output arithmetic
	typedef struct packed {
		logic [CODE_W-1:0] val;   // leading one followed by the suffix bits
		logic [BITS_W-1:0] bits;
		logic              ovf;
	} res_t;

endpackage

// ===== rtl/core/exp_golomb_stream_decoder.sv =====
// bit-serial order-0 exp-golomb decoder for a byte stream
//
//  channel  dir  tdata (low bit up)                          tuser     tlast
//  s_*      in   stream_byte[7:0]                            restart   -
//  m_*      out  code_number[31:0] signed_number[64:32]      overflow  last_of_byte
//                code_bits[70:65] zero pad[71]
//  cfg_*    in   cfg_wdata = drop_prevention_bytes, written when cfg_wen is high
//
// a data byte is accepted and then decoded in 8 bit steps, one per cycle while no stall holds the shifter
// a dropped prevention byte gives no result
// each result is parked one stage so the last one of a byte can be flagged
// a stall on m_tready holds the bit shifter when a second result is due
// reset clears all control state, drop_prevention_bytes resets to 1
`include "assert_macros.svh"

module exp_golomb_stream_decoder import expg_pkg::*; #(
	parameter int MAX_PREFIX = DEF_MAX_PREFIX
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // stream_byte[7:0]
	input  logic        s_tuser,   // restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // code_number, signed_number, code_bits, pad
	output logic        m_tuser,   // overflow
	output logic        m_tlast    // last_of_byte
);

	localparam int CNT_W = $clog2(BITS_PER_BYTE + 1);
	localparam logic [BITS_W-1:0] MAXP = BITS_W'(MAX_PREFIX);
	localparam logic [BITS_W-1:0] OVF_BITS = BITS_W'(MAX_PREFIX + 1);

	// control state
	logic                     drop_q;
	logic                     in_suf_q;
	logic [BITS_W-1:0]        prefix_q;
	logic [BITS_W-1:0]        left_q;
	logic [CODE_W-1:0]        val_q;
	logic [1:0]               zrun_q;
	logic [BITS_PER_BYTE-1:0] shift_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     pend_valid_q;
	res_t                     pend_q;
	logic                     out_valid_q;

	// output payload
	logic [CODE_W-1:0]   out_num_q;
	logic [SIGNED_W-1:0] out_sgn_q;
	logic [BITS_W-1:0]   out_bits_q;
	logic                out_ovf_q;
	logic                out_last_q;

	logic                in_xfer;
	logic [1:0]          zbase;
	logic                drop_now;
	logic                out_free;
	logic                bit_now;
	logic                res_now;
	res_t                res;
	logic                step;
	logic                flush;
	logic                out_load;
	logic                out_last_n;
	logic                in_suf_n;
	logic [BITS_W-1:0]   prefix_n;
	logic [BITS_W-1:0]   left_n;
	logic [CODE_W-1:0]   val_n;
	logic [SIGNED_W-1:0] half;

	// input side
	assign in_xfer  = s_tvalid && s_tready;
	assign zbase    = s_tuser ? 2'd0 : zrun_q;
	assign drop_now = drop_q && (zbase == 2'd2) && (s_tdata == PREVENTION_BYTE);
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (cnt_q == '0) && (!pend_valid_q || out_free);

	// one bit of the decode
	always_comb begin
		bit_now  = shift_q[BITS_PER_BYTE-1];
		res_now  = 1'b0;
		res      = '0;
		in_suf_n = in_suf_q;
		prefix_n = prefix_q;
		left_n   = left_q;
		val_n    = val_q;
		if (!in_suf_q) begin
			if (!bit_now) begin
				if (prefix_q >= MAXP) begin
					res_now  = 1'b1;
					res.val  = CODE_W'(1);
					res.bits = OVF_BITS;
					res.ovf  = 1'b1;
					prefix_n = '0;
				end else begin
					prefix_n = prefix_q + BITS_W'(1);
				end
			end else if (prefix_q == '0) begin
				res_now  = 1'b1;
				res.val  = CODE_W'(1);
				res.bits = BITS_W'(1);
			end else begin
				in_suf_n = 1'b1;
				left_n   = prefix_q;
				val_n    = CODE_W'(1);
			end
		end else begin
			val_n  = {val_q[CODE_W-2:0], bit_now};
			left_n = left_q - BITS_W'(1);
			if (left_q == BITS_W'(1)) begin
				res_now  = 1'b1;
				res.val  = val_n;
				res.bits = {prefix_q[BITS_W-2:0], 1'b1};
				in_suf_n = 1'b0;
				prefix_n = '0;
				left_n   = '0;
			end
		end
	end

	// stepping, parking and output loading
	assign step       = (cnt_q != '0) && !(res_now && pend_valid_q && !out_free);
	assign flush      = (cnt_q == '0) && pend_valid_q && out_free;
	assign out_load   = flush || (step && res_now && pend_valid_q);
	assign out_last_n = flush;

	// output arithmetic from the parked code
	assign half = {2'b00, pend_q.val[CODE_W-1:1]};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q       <= 1'b1;
			in_suf_q     <= 1'b0;
			prefix_q     <= '0;
			left_q       <= '0;
			val_q        <= '0;
			zrun_q       <= 2'd0;
			shift_q      <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				drop_q <= cfg_wdata;
			end
			if (in_xfer) begin
				if (s_tuser) begin
					in_suf_q <= 1'b0;
					prefix_q <= '0;
					left_q   <= '0;
					val_q    <= '0;
				end
				if (drop_now) begin
					zrun_q <= 2'd0;
				end else begin
					if (s_tdata == 8'h00) begin
						zrun_q <= (zbase == 2'd2) ? 2'd2 : zbase + 2'd1;
					end else begin
						zrun_q <= 2'd0;
					end
					shift_q <= s_tdata;
					cnt_q   <= CNT_W'(BITS_PER_BYTE);
				end
			end
			if (step) begin
				in_suf_q <= in_suf_n;
				prefix_q <= prefix_n;
				left_q   <= left_n;
				val_q    <= val_n;
				shift_q  <= {shift_q[BITS_PER_BYTE-2:0], 1'b0};
				cnt_q    <= cnt_q - CNT_W'(1);
				if (res_now) begin
					pend_q       <= res;
					pend_valid_q <= 1'b1;
				end
			end
			if (flush) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_num_q  <= pend_q.val - CODE_W'(1);
			out_sgn_q  <= pend_q.val[0] ? (SIGNED_W'(0) - half) : half;
			out_bits_q <= pend_q.bits;
			out_ovf_q  <= pend_q.ovf;
			out_last_q <= out_last_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_bits_q, out_sgn_q, out_num_q};
	assign m_tuser  = out_ovf_q;
	assign m_tlast  = out_last_q;

	// checks
	`ASSERT_CLK(a_load_count, (in_xfer && !drop_now) |=> (cnt_q == CNT_W'(BITS_PER_BYTE)), "bit count not loaded")
	`ASSERT_CLK(a_suffix_left, in_suf_q |-> ((left_q != '0) && (left_q <= prefix_q)), "suffix count out of range")
	`ASSERT_CLK(a_prefix_limit, prefix_q <= MAXP, "prefix above limit")
	`ASSERT_CLK(a_flush_done, flush |=> !pend_valid_q, "parked result not flushed")

endmodule

// ===== test/expg_checker.sv =====
// checker that predicts and compares the decoded codes of the exp-golomb stream decoder
`timescale 1ns / 1ps

module expg_checker import expg_pkg::*; #(
	parameter int MAX_PREFIX = DEF_MAX_PREFIX
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // stream_byte[7:0]
	input  logic        s_tuser,   // restart
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,   // code_number, signed_number, code_bits, pad
	input  logic        m_tuser,   // overflow
	input  logic        m_tlast,   // last_of_byte
	output int          errors,
	output int          pending,
	output int          checked,
	output int          overflows
);

	// one expected code as it should leave the block
	typedef struct packed {
		logic [CODE_W-1:0]   num;
		logic [SIGNED_W-1:0] sgn;
		logic [BITS_W-1:0]   bits;
		logic                ovf;
		logic                last;
	} code_t;

	code_t       due_codes[$];
	code_t       want;

	// shadow copy of the decoder state
	logic        drop_epb;
	logic        in_suffix;
	logic [5:0]  prefix_len;
	logic [5:0]  suffix_left;
	logic [31:0] suffix_val;
	logic [1:0]  zero_run;

	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
		overflows = 0;
	end

	// unsigned value plus its signed mapping
	function automatic code_t make_code(input logic [31:0] num, input logic [5:0] bits,
			input logic ovf);
		code_t       c;
		logic [32:0] wide;
		wide = {1'b0, num};
		c.num = num;
		c.bits = bits;
		c.ovf = ovf;
		c.last = 1'b0;
		if (ovf) begin
			c.sgn = '0;
		end else if (num[0]) begin
			c.sgn = (wide + 33'd1) >> 1;
		end else begin
			c.sgn = -(wide >> 1);
		end
		return c;
	endfunction

	task automatic clear_code();
		in_suffix = 1'b0;
		prefix_len = '0;
		suffix_left = '0;
		suffix_val = '0;
	endtask

	// walk one stream byte msb first and queue the codes it completes
	task automatic decode_byte(input logic [7:0] b, input logic rst);
		code_t       found [BITS_PER_BYTE];
		int          n;
		logic        bitv;
		logic [32:0] num;
		n = 0;
		if (rst) begin
			clear_code();
			zero_run = 2'd0;
		end
		// emulation prevention byte after two zero bytes
		if (drop_epb && zero_run == 2'd2 && b == PREVENTION_BYTE) begin
			zero_run = 2'd0;
			return;
		end
		if (b == 8'h00) begin
			if (zero_run != 2'd2)
				zero_run = zero_run + 2'd1;
		end else begin
			zero_run = 2'd0;
		end
		for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
			bitv = b[i];
			if (!in_suffix) begin
				if (!bitv) begin
					// prefix too long, abandon the code
					if (prefix_len >= MAX_PREFIX) begin
						found[n] = make_code('0, 6'(MAX_PREFIX + 1), 1'b1);
						n++;
						clear_code();
					end else begin
						prefix_len = prefix_len + 6'd1;
					end
				end else if (prefix_len == 0) begin
					found[n] = make_code('0, 6'd1, 1'b0);
					n++;
					clear_code();
				end else begin
					in_suffix = 1'b1;
					suffix_left = prefix_len;
					suffix_val = '0;
				end
			end else begin
				suffix_val = {suffix_val[30:0], bitv};
				suffix_left = suffix_left - 6'd1;
				if (suffix_left == 0) begin
					num = (33'd1 << prefix_len) - 33'd1 + {1'b0, suffix_val};
					found[n] = make_code(num[31:0], 6'(2 * prefix_len + 1), 1'b0);
					n++;
					clear_code();
				end
			end
		end
		if (n > 0)
			found[n-1].last = 1'b1;
		for (int k = 0; k < n; k++)
			due_codes.push_back(found[k]);
	endtask

	// follow config, input and output transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_codes.delete();
			drop_epb = 1'b1;
			clear_code();
			zero_run = 2'd0;
		end else begin
			if (cfg_wen)
				drop_epb = cfg_wdata;
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tuser);
			if (m_tvalid && m_tready) begin
				if (due_codes.size() == 0) begin
					$error("unexpected code transfer: code_number %0d", m_tdata[31:0]);
					errors++;
				end else begin
					want = due_codes.pop_front();
					checked++;
					if (want.ovf)
						overflows++;
					if (m_tdata[31:0] !== want.num) begin
						$error("code_number: expected %0d, got %0d", want.num, m_tdata[31:0]);
						errors++;
					end
					if (m_tdata[64:32] !== want.sgn) begin
						$error("signed_number: expected %0d, got %0d",
							$signed(want.sgn), $signed(m_tdata[64:32]));
						errors++;
					end
					if (m_tdata[70:65] !== want.bits) begin
						$error("code_bits: expected %0d, got %0d", want.bits, m_tdata[70:65]);
						errors++;
					end
					if (m_tuser !== want.ovf) begin
						$error("overflow: expected %0d, got %0d", want.ovf, m_tuser);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$error("last_of_byte: expected %0d, got %0d", want.last, m_tlast);
						errors++;
					end
				end
			end
		end
		pending = due_codes.size();
	end

endmodule

// ===== test/tb.sv =====
// testbench top for the exp-golomb stream decoder: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb import expg_pkg::*; ();

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // stream_byte[7:0]
	logic        s_tuser = 1'b0;    // restart
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;           // code_number, signed_number, code_bits, pad
	logic        m_tuser;           // overflow
	logic        m_tlast;           // last_of_byte

	int          errors;
	int          pending;
	int          checked;
	int          overflows;

	// generator state
	logic        calm = 1'b0;
	logic        drop_mode = 1'b1;
	logic [1:0]  zrun = 2'd0;
	logic        bitq[$];
	int          sent = 0;

	exp_golomb_stream_decoder #(.MAX_PREFIX(DEF_MAX_PREFIX)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	expg_checker #(.MAX_PREFIX(DEF_MAX_PREFIX)) chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.errors(errors), .pending(pending), .checked(checked), .overflows(overflows)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver stalls at random unless in a calm stretch
	always @(posedge clk)
		m_tready <= calm || ($urandom_range(99) >= 18);

	// one byte transfer, with random gaps ahead of it unless in a calm stretch
	task automatic send_byte(input logic [7:0] b, input logic r);
		if (!calm) begin
			while ($urandom_range(99) < 18) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= r;
		do @(posedge clk); while (!s_tready);
		sent++;
		// track the zero run as the block sees it
		if (r)
			zrun = 2'd0;
		if (drop_mode && zrun == 2'd2 && b == PREVENTION_BYTE)
			zrun = 2'd0;
		else if (b == 8'h00)
			zrun = (zrun == 2'd2) ? 2'd2 : zrun + 2'd1;
		else
			zrun = 2'd0;
	endtask

	// data byte of a clean stream, protected like an encoder would
	task automatic emit_byte(input logic [7:0] b);
		if (drop_mode && zrun == 2'd2 && b <= PREVENTION_BYTE)
			send_byte(PREVENTION_BYTE, 1'b0);
		send_byte(b, 1'b0);
	endtask

	task automatic add_code(input int m, input logic [31:0] suf);
		repeat (m) bitq.push_back(1'b0);
		bitq.push_back(1'b1);
		for (int i = m - 1; i >= 0; i--)
			bitq.push_back(suf[i]);
	endtask

	task automatic flush_bits();
		logic [7:0] b;
		while (bitq.size() >= 8) begin
			for (int i = 7; i >= 0; i--)
				b[i] = bitq.pop_front();
			emit_byte(b);
		end
	endtask

	// drain all expected codes, then let an in-flight byte finish
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (32) @(posedge clk);
	endtask

	task automatic write_drop(input logic v);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		drop_mode = v;
	endtask

	// mostly well-formed code streams with some noise mixed in
	task automatic run_random(input int count);
		int stop;
		int pick;
		int sel;
		int m;
		stop = sent + count;
		while (sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				sel = $urandom_range(99);
				m = (sel < 60) ? $urandom_range(3) :
					(sel < 90) ? $urandom_range(12, 4) : $urandom_range(31, 13);
				add_code(m, $urandom);
				flush_bits();
			end else if (pick < 75) begin
				repeat ($urandom_range(40, 32)) bitq.push_back(1'b0);
				flush_bits();
			end else if (pick < 85) begin
				send_byte(8'($urandom_range(255)), 1'b0);
			end else if (pick < 90) begin
				send_byte(8'h00, 1'b0);
				send_byte(8'h00, 1'b0);
				send_byte(PREVENTION_BYTE, 1'b0);
			end else if (pick < 95) begin
				bitq.delete();
				send_byte(8'($urandom_range(255)), 1'b1);
			end else begin
				send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_drop(1'b1);
		// eight one-bit codes in one byte
		send_byte(8'hFF, 1'b0);
		// 32 zero bits overflow the prefix
		repeat (4) send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		// prevention byte dropped, a second one right after is data
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(PREVENTION_BYTE, 1'b0);
		send_byte(PREVENTION_BYTE, 1'b0);
		// restart throws away the partial code
		send_byte(8'hA5, 1'b1);
		// longest legal code, all-ones suffix across bytes
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFE, 1'b0);
		// restart also clears the zero run
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(PREVENTION_BYTE, 1'b1);
		wait_idle();

		// dropping off: 0x03 after two zeros is data
		write_drop(1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(PREVENTION_BYTE, 1'b0);
		run_random(65);
		wait_idle();

		write_drop(1'b1);
		run_random(20);
		calm = 1'b1;
		run_random(30);
		calm = 1'b0;
		run_random(15);
		wait_idle();

		write_drop(1'b0);
		run_random(65);
		wait_idle();

		write_drop(1'($urandom_range(1)));
		run_random(65);
		wait_idle();

		$display("tb: %0d bytes sent over five drop settings, %0d codes checked", sent, checked);
		$display("tb: %0d of the checked codes were prefix overflows", overflows);
		if (errors == 0 && pending == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// hard stop if the run hangs
	initial begin
		#5_000_000;
		$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/expg_pkg.sv
rtl/core/exp_golomb_stream_decoder.sv
test/expg_checker.sv
test/tb.sv
